// ===== hdl/rbol_pkg.sv =====
// Shared constants for the overwriting ring buffer with byte-offset lookup.
// Used by the core and by its port checker; depends on nothing else.
package rbol_pkg;

  // Ring geometry.
  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  // Field widths.
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned POS_W    = 20;
  localparam int unsigned ENTRY_W  = HANDLE_W + LENGTH_W;

  // Stream widths: input tdata is 68 bits of fields padded to 72.
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 64;
  localparam int unsigned M_TUSER_W = 2;

  // Operation codes carried on the input tuser.
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_FIND = 1'b1;

  // Bit positions inside the output tuser.
  localparam int unsigned TUSER_FOUND   = 0;
  localparam int unsigned TUSER_DROPPED = 1;

endpackage

// ===== hdl/ring_buffer_overwrite_offset_lookup_core.sv =====
// Flow: an add goes from accept through ST_ADD and ST_OUT to the output register; a find
// goes through ST_FIND, walking 1 up to SLOTS entries, then ST_OUT, and a find on an
// empty ring goes straight to ST_OUT; the walk reads one entry per cycle from the memory.
// Throughput: one item at a time; the next beat is taken once the result is
// registered on the output, even while that result still waits to be taken.
// Reset clears the indices, the full flag and all handshake state, not the slots.
module ring_buffer_overwrite_offset_lookup_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] new_handle, [47:32] new_length, [67:48] byte_position, [71:68] zero
  input  logic [rbol_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] result_handle, [47:32] result_length, [63:48] offset_within
  output logic [rbol_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] found, [1] dropped
  output logic [rbol_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

  localparam int unsigned IDX_W = rbol_pkg::IDX_W;
  localparam int unsigned CNT_W = rbol_pkg::CNT_W;
  localparam int unsigned HW    = rbol_pkg::HANDLE_W;
  localparam int unsigned LW    = rbol_pkg::LENGTH_W;
  localparam int unsigned PW    = rbol_pkg::POS_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_FIND = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(rbol_pkg::SLOTS - 1)) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] wr_q, wr_d, rd_q, rd_d, idx_q, idx_d;
  logic             full_q, full_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [HW-1:0]    new_handle_q, new_handle_d;
  logic [LW-1:0]    new_length_q, new_length_d;

  logic             res_found_q, res_found_d, res_dropped_q, res_dropped_d;
  logic [HW-1:0]    res_handle_q, res_handle_d;
  logic [LW-1:0]    res_length_q, res_length_d, res_within_q, res_within_d;

  logic             m_valid_q, m_valid_d;
  logic [rbol_pkg::M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [rbol_pkg::M_TUSER_W-1:0] m_user_q, m_user_d;

  logic [rbol_pkg::ENTRY_W-1:0] slot_mem_q [rbol_pkg::SLOTS];
  logic [rbol_pkg::ENTRY_W-1:0] rdata_q;
  logic [IDX_W-1:0]             rd_addr;
  logic                         mem_we;

  logic             s_fire;
  logic             out_free;
  logic [HW-1:0]    rd_handle;
  logic [LW-1:0]    rd_length;
  logic [IDX_W-1:0] walk_next;
  logic [CNT_W-1:0] walk_cnt;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign rd_handle = rdata_q[HW-1:0];
  assign rd_length = rdata_q[HW+LW-1:HW];
  assign walk_next = next_idx(idx_q);
  assign walk_cnt  = cnt_q + CNT_W'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[wr_q] <= {new_length_q, new_handle_q};
    end
    rdata_q <= slot_mem_q[rd_addr];
  end

  // Read address: the oldest entry when idle, the next entry during a walk.
  always_comb begin
    rd_addr = rd_q;
    if (state_q == ST_FIND) begin
      rd_addr = walk_next;
    end
  end

  // Sequencer and datapath.
  always_comb begin
    state_d       = state_q;
    wr_d          = wr_q;
    rd_d          = rd_q;
    full_d        = full_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    pos_d         = pos_q;
    new_handle_d  = new_handle_q;
    new_length_d  = new_length_q;
    res_found_d   = res_found_q;
    res_dropped_d = res_dropped_q;
    res_handle_d  = res_handle_q;
    res_length_d  = res_length_q;
    res_within_d  = res_within_q;
    m_valid_d     = m_valid_q;
    m_data_d      = m_data_q;
    m_user_d      = m_user_q;
    mem_we        = 1'b0;

    // The output register empties when its beat is taken.
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          new_handle_d  = s_axis_tdata[HW-1:0];
          new_length_d  = s_axis_tdata[HW+LW-1:HW];
          pos_d         = s_axis_tdata[HW+LW+PW-1:HW+LW];
          idx_d         = rd_q;
          cnt_d         = '0;
          res_found_d   = 1'b0;
          res_dropped_d = 1'b0;
          res_handle_d  = '0;
          res_length_d  = '0;
          res_within_d  = '0;
          if (s_axis_tuser == rbol_pkg::MODE_ADD) begin
            state_d = ST_ADD;
          end else if (!full_q && (wr_q == rd_q)) begin
            // Empty ring: nothing to walk.
            state_d = ST_OUT;
          end else begin
            state_d = ST_FIND;
          end
        end
      end

      ST_ADD: begin
        // The oldest entry was read at accept; overwrite it if the ring is full.
        mem_we = 1'b1;
        if (full_q) begin
          res_dropped_d = 1'b1;
          res_handle_d  = rd_handle;
          rd_d          = next_idx(rd_q);
        end
        wr_d    = next_idx(wr_q);
        full_d  = (wr_d == rd_d);
        state_d = ST_OUT;
      end

      ST_FIND: begin
        // One stored entry per cycle, oldest first.
        if (pos_q < PW'(rd_length)) begin
          res_found_d  = 1'b1;
          res_handle_d = rd_handle;
          res_length_d = rd_length;
          res_within_d = pos_q[LW-1:0];
          state_d      = ST_OUT;
        end else if ((walk_cnt == CNT_W'(rbol_pkg::SLOTS)) ||
                     (!full_q && (walk_next == wr_q))) begin
          state_d = ST_OUT;
        end else begin
          idx_d = walk_next;
          cnt_d = walk_cnt;
          pos_d = pos_q - PW'(rd_length);
        end
      end

      ST_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {res_within_q, res_length_q, res_handle_q};
          m_user_d  = '0;
          m_user_d[rbol_pkg::TUSER_FOUND]   = res_found_q;
          m_user_d[rbol_pkg::TUSER_DROPPED] = res_dropped_q;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wr_q      <= '0;
      rd_q      <= '0;
      full_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      full_q    <= full_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    cnt_q         <= cnt_d;
    pos_q         <= pos_d;
    new_handle_q  <= new_handle_d;
    new_length_q  <= new_length_d;
    res_found_q   <= res_found_d;
    res_dropped_q <= res_dropped_d;
    res_handle_q  <= res_handle_d;
    res_length_q  <= res_length_d;
    res_within_q  <= res_within_d;
    m_data_q      <= m_data_d;
    m_user_q      <= m_user_d;
  end

endmodule

// ===== hdl/rbol_checker.sv =====
// Port-level checks for the overwriting ring buffer core, with its bind.
// Depends on rbol_pkg and watches the core's ports only.
module rbol_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rbol_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [rbol_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  logic found;
  logic dropped;

  assign found   = m_axis_tuser[rbol_pkg::TUSER_FOUND];
  assign dropped = m_axis_tuser[rbol_pkg::TUSER_DROPPED];

  // A stalled result beat holds its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A find hit and an overwrite never come from the same item.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(found && dropped))
    else $error("found and dropped both set");

  // Without a hit, length and inner offset are zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !found |-> m_axis_tdata[63:32] == '0)
    else $error("length or offset nonzero without a hit");

  // A hit lies inside its entry.
  a_hit_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && found |-> m_axis_tdata[63:48] < m_axis_tdata[47:32])
    else $error("inner offset outside the matching entry");

endmodule

bind ring_buffer_overwrite_offset_lookup_core rbol_checker u_rbol_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
